>>> sv/bba_pkg.sv
package bba_pkg;

  // Fixed widths of the transaction fields.
  localparam int REQ_W     = 16;
  localparam int NEED_W    = 17;
  localparam int ADDR_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int OUT_LVL_W = 3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_GRANT     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_BLOCK  = 2'd2;

  // Allocation sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEVEL,
    ST_FIND,
    ST_READ,
    ST_SPLIT,
    ST_DONE
  } bba_state_t;

endpackage

>>> sv/bba_size.sv
module bba_size import bba_pkg::*; #(
  parameter int MIN_LEVEL  = 5,
  parameter int NUM_LEVELS = 8,
  localparam int LVL_W     = $clog2(NUM_LEVELS)
) (
  input  logic              clk,
  input  logic [NEED_W-1:0] need,
  output logic [LVL_W-1:0]  tgt_lvl_r,
  output logic              fit_r
);

  logic [LVL_W-1:0] tgt_lvl_nxt;
  logic             fit_nxt;

  // Smallest level at or above the minimum whose block holds the total size.
  always_comb begin
    tgt_lvl_nxt = '0;
    fit_nxt     = 1'b0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (l >= MIN_LEVEL && 32'(need) <= (32'd1 << l)) begin
        tgt_lvl_nxt = LVL_W'(l);
        fit_nxt     = 1'b1;
      end
    end
  end

  // Registered result of the level search.
  always_ff @(posedge clk) begin
    tgt_lvl_r <= tgt_lvl_nxt;
    fit_r     <= fit_nxt;
  end

endmodule

>>> sv/buddy_block_allocator.sv
// Channel   Ports                                      Handshake
// input     start, busy, in_req_size                   start high while busy low
// result    out_valid, out_status, out_grant_address,  out_valid strobe, one cycle
//           out_granted_level
// config    cfg_valid, cfg_ready, cfg_data             cfg_valid and cfg_ready high
//
// A failed request (too large or no free block) goes from ST_FIND straight to
// ST_DONE. A grant walks the splits from the source level down to the target
// level; the split walk writes one level per cycle through the offset memory
// write port. A new request is taken the cycle after the result strobe. Reset
// (synchronous, active low) leaves the pool as one free block at the top level.
// The receiver cannot stall the result.
module buddy_block_allocator import bba_pkg::*; #(
  parameter int MIN_LEVEL    = 5,
  parameter int NUM_LEVELS   = 8,
  parameter int HEADER_BYTES = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [REQ_W-1:0]     in_req_size,
  output logic                 out_valid,
  output logic [STATUS_W-1:0]  out_status,
  output logic [ADDR_W-1:0]    out_grant_address,
  output logic [OUT_LVL_W-1:0] out_granted_level,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [ADDR_W-1:0]    cfg_data
);

  localparam int LVL_W = $clog2(NUM_LEVELS);
  localparam int OFF_W = NUM_LEVELS - 1;
  localparam int TOP   = NUM_LEVELS - 1;

  bba_state_t state_r, state_nxt;

  logic [ADDR_W-1:0]    pool_base_r;
  logic [NEED_W-1:0]    need_r;
  logic [NUM_LEVELS-1:0] valid_r;
  logic [LVL_W-1:0]     cur_r;
  logic [OFF_W-1:0]     offset_r;
  logic [STATUS_W-1:0]  status_r;
  logic [ADDR_W-1:0]    addr_r;
  logic [OUT_LVL_W-1:0] glvl_r;

  logic [LVL_W-1:0]     tgt_lvl_r;
  logic                 fit_r;
  logic [LVL_W-1:0]     src_lvl;
  logic                 src_found;
  logic [LVL_W-1:0]     split_lvl;

  logic [OFF_W-1:0]     ofs_mem [NUM_LEVELS];
  logic [OFF_W-1:0]     mem_rdata_r;
  logic                 mem_we;
  logic [LVL_W-1:0]     mem_raddr;

  // Target level search on the registered total size.
  bba_size #(
    .MIN_LEVEL  (MIN_LEVEL),
    .NUM_LEVELS (NUM_LEVELS)
  ) u_size (
    .clk       (clk),
    .need      (need_r),
    .tgt_lvl_r (tgt_lvl_r),
    .fit_r     (fit_r)
  );

  // Lowest non-empty level at or above the target.
  always_comb begin
    src_lvl   = '0;
    src_found = 1'b0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (LVL_W'(l) >= tgt_lvl_r && valid_r[l]) begin
        src_lvl   = LVL_W'(l);
        src_found = 1'b1;
      end
    end
  end

  assign split_lvl = cur_r - LVL_W'(1);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_LEVEL;
      ST_LEVEL: state_nxt = ST_FIND;
      ST_FIND: begin
        if (fit_r && src_found) state_nxt = ST_READ;
        else                    state_nxt = ST_DONE;
      end
      ST_READ:  state_nxt = ST_SPLIT;
      ST_SPLIT: if (cur_r == tgt_lvl_r) state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Output and memory control decode.
  always_comb begin
    busy      = 1'b1;
    out_valid = 1'b0;
    mem_we    = 1'b0;
    mem_raddr = src_lvl;
    case (state_r)
      ST_IDLE:  busy = 1'b0;
      ST_SPLIT: mem_we = (cur_r != tgt_lvl_r);
      ST_DONE:  out_valid = 1'b1;
      default:  mem_raddr = src_lvl;
    endcase
  end

  assign cfg_ready         = 1'b1;
  assign out_status        = status_r;
  assign out_grant_address = addr_r;
  assign out_granted_level = glvl_r;

  // Free-block offset memory: one entry per level, with a registered read.
  // The top-level entry is never written; its offset is always zero.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ofs_mem[split_lvl] <= offset_r + (OFF_W'(1) << split_lvl);
    end
    mem_rdata_r <= ofs_mem[mem_raddr];
  end

  // Control state: sequencer, free flags and the base register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= {1'b1, {(NUM_LEVELS-1){1'b0}}};
      pool_base_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) pool_base_r <= cfg_data;
      if (state_r == ST_READ) valid_r[cur_r] <= 1'b0;
      if (mem_we) valid_r[split_lvl] <= 1'b1;
    end
  end

  // Datapath registers for the transaction in flight.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (start) need_r <= NEED_W'(in_req_size) + NEED_W'(HEADER_BYTES);
      end
      ST_FIND: begin
        cur_r    <= src_lvl;
        addr_r   <= '0;
        glvl_r   <= '0;
        status_r <= !fit_r ? STATUS_TOO_LARGE : STATUS_NO_BLOCK;
      end
      ST_READ: begin
        offset_r <= (cur_r == LVL_W'(TOP)) ? '0 : mem_rdata_r;
      end
      ST_SPLIT: begin
        if (cur_r != tgt_lvl_r) begin
          cur_r <= split_lvl;
        end else begin
          status_r <= STATUS_GRANT;
          addr_r   <= pool_base_r + ADDR_W'(offset_r) + ADDR_W'(HEADER_BYTES);
          glvl_r   <= OUT_LVL_W'(tgt_lvl_r);
        end
      end
      default: begin
        cur_r <= cur_r;
      end
    endcase
  end

`ifndef SYNTHESIS
  // A result is a single-cycle strobe.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // An accepted transaction makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // Failed requests carry zero address and level.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STATUS_GRANT) |->
      (out_grant_address == '0 && out_granted_level == '0))
    else $error("failed request returned nonzero address or level");

  // The split walk never passes below the target level.
  a_split_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SPLIT) |-> (cur_r >= tgt_lvl_r))
    else $error("split walk below target level");
`endif

endmodule

>>> sim/buddy_block_allocator_tb.sv
`timescale 1ns / 1ps

module buddy_block_allocator_tb import bba_pkg::*; ();

  localparam int MIN_LEVEL    = 5;
  localparam int NUM_LEVELS   = 8;
  localparam int HEADER_BYTES = 24;
  localparam int TOP_LEVEL    = NUM_LEVELS - 1;
  localparam int OFF_W        = NUM_LEVELS - 1;
  localparam int RANDOM_ITEMS = 1600;
  localparam int STALL_LIMIT  = 5000;

  localparam logic [ADDR_W-1:0] BASE_HIGH = 32'hFFFF_FF00;

  // A pending transaction is either an allocation request or a base write.
  typedef enum logic {
    ITEM_REQ,
    ITEM_CFG
  } item_kind_t;

  typedef struct packed {
    item_kind_t        kind;
    logic [ADDR_W-1:0] value;
  } pend_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [ADDR_W-1:0]    addr;
    logic [OUT_LVL_W-1:0] level;
  } grant_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [REQ_W-1:0]     in_req_size = '0;
  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic [ADDR_W-1:0]    out_grant_address;
  logic [OUT_LVL_W-1:0] out_granted_level;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [ADDR_W-1:0]    cfg_data = '0;

  pend_item_t pend_q[$];
  grant_t     grant_q[$];

  // Shadow copy of the allocator state.
  logic [ADDR_W-1:0] pool_base_m;
  logic              free_valid_m [NUM_LEVELS];
  logic [OFF_W-1:0]  free_off_m [NUM_LEVELS];

  int  hold_off;
  int  in_flight;
  bit  calm;
  int  idle_cycles;
  bit  failed;

  buddy_block_allocator #(
    .MIN_LEVEL   (MIN_LEVEL),
    .NUM_LEVELS  (NUM_LEVELS),
    .HEADER_BYTES(HEADER_BYTES)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_size      (in_req_size),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_grant_address(out_grant_address),
    .out_granted_level(out_granted_level),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Predict one allocation and update the shadow free lists.
  function automatic grant_t allocate(input logic [REQ_W-1:0] size);
    grant_t           res;
    logic [NEED_W-1:0] need;
    int               lvl;
    int               src;
    logic [OFF_W-1:0] off;
    res = '0;
    need = NEED_W'(size) + NEED_W'(HEADER_BYTES);
    lvl = MIN_LEVEL;
    while (lvl < NUM_LEVELS && (64'd1 << lvl) < 64'(need)) lvl++;
    if (lvl >= NUM_LEVELS) begin
      res.status = STATUS_TOO_LARGE;
      return res;
    end
    src = lvl;
    while (src < NUM_LEVELS && !free_valid_m[src]) src++;
    if (src >= NUM_LEVELS) begin
      res.status = STATUS_NO_BLOCK;
      return res;
    end
    // Take the source block and park each upper-half buddy on the way down.
    off = free_off_m[src];
    free_valid_m[src] = 1'b0;
    while (src > lvl) begin
      src--;
      free_off_m[src] = off + OFF_W'(64'd1 << src);
      free_valid_m[src] = 1'b1;
    end
    res.status = STATUS_GRANT;
    res.addr = pool_base_m + ADDR_W'(off) + ADDR_W'(HEADER_BYTES);
    res.level = OUT_LVL_W'(lvl);
    return res;
  endfunction

  // Driver: presents queued transactions with random gaps. A base write waits
  // until no request is in flight and the block is idle.
  always @(posedge clk) begin
    pend_item_t nxt;
    bit req_taken;
    bit cfg_taken;
    bit drive_req;
    bit drive_cfg;
    bit presented;
    int flight;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      hold_off <= 0;
      in_flight <= 0;
      calm <= 1'b0;
    end else begin
      req_taken = start && !busy;
      cfg_taken = cfg_valid && cfg_ready;
      drive_req = start && !req_taken;
      drive_cfg = cfg_valid && !cfg_taken;
      presented = 1'b0;
      flight = in_flight + int'(req_taken) - int'(out_valid);
      in_flight <= flight;
      if (!drive_req && !drive_cfg) begin
        if (hold_off > 0) begin
          hold_off <= hold_off - 1;
        end else if (pend_q.size() > 0) begin
          nxt = pend_q[0];
          if (nxt.kind == ITEM_REQ) begin
            in_req_size <= nxt.value[REQ_W-1:0];
            drive_req = 1'b1;
            presented = 1'b1;
          end else if (flight == 0 && !busy && !req_taken) begin
            cfg_data <= nxt.value;
            drive_cfg = 1'b1;
            presented = 1'b1;
          end
        end
      end
      if (presented) begin
        void'(pend_q.pop_front());
        // Occasionally switch between gapped traffic and back-to-back stretches.
        if ($urandom_range(49, 0) == 0) calm <= !calm;
        hold_off <= calm ? 0 : int'($urandom_range(9, 0));
      end
      start <= drive_req;
      cfg_valid <= drive_cfg;
    end
  end

  // Monitor: checks each result against the oldest prediction, then records
  // new requests and base writes taken at this edge.
  always @(posedge clk) begin
    grant_t want;
    if (!rst_n) begin
      pool_base_m = '0;
      for (int k = 0; k < NUM_LEVELS; k++) begin
        free_valid_m[k] = 1'b0;
        free_off_m[k] = '0;
      end
      free_valid_m[TOP_LEVEL] = 1'b1;
    end else begin
      if (out_valid) begin
        if (grant_q.size() == 0) begin
          $error("unexpected result: status %0d, grant_address %h", out_status,
                 out_grant_address);
          failed = 1'b1;
        end else begin
          want = grant_q.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            failed = 1'b1;
          end
          if (out_grant_address !== want.addr) begin
            $error("grant_address: expected %h, actual %h", want.addr, out_grant_address);
            failed = 1'b1;
          end
          if (out_granted_level !== want.level) begin
            $error("granted_level: expected %0d, actual %0d", want.level,
                   out_granted_level);
            failed = 1'b1;
          end
        end
      end
      if (start && !busy) grant_q.push_back(allocate(in_req_size));
      if (cfg_valid && cfg_ready) pool_base_m = cfg_data;
    end
  end

  // Watchdog on cycles without any accepted transaction or result.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  function automatic pend_item_t req_item(input logic [REQ_W-1:0] size);
    return '{kind: ITEM_REQ, value: ADDR_W'(size)};
  endfunction

  function automatic pend_item_t base_item(input logic [ADDR_W-1:0] base);
    return '{kind: ITEM_CFG, value: base};
  endfunction

  initial begin
    failed = 1'b0;

    // Directed part: highest base, size boundaries, splits, a request that
    // skips smaller free blocks, exhaustion, and the lowest base with more requests.
    pend_q.push_back(base_item(BASE_HIGH));
    pend_q.push_back(req_item(16'hFFFF));
    pend_q.push_back(req_item(16'd105));
    pend_q.push_back(req_item(16'd0));
    pend_q.push_back(base_item(ADDR_W'($urandom_range(BASE_HIGH, 0))));
    pend_q.push_back(req_item(16'd104));
    pend_q.push_back(req_item(16'd9));
    pend_q.push_back(req_item(16'd40));
    pend_q.push_back(base_item('0));
    pend_q.push_back(req_item(16'd8));
    pend_q.push_back(req_item(16'd0));
    pend_q.push_back(req_item(16'd41));
    pend_q.push_back(req_item(16'h8000));
    pend_q.push_back(req_item(16'h5555));
    pend_q.push_back(req_item(16'hAAAA));

    // Random part: mostly sizes that fit the pool, the rest over the full range,
    // with an occasional new base between phases.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(199, 0) == 0) begin
        case ($urandom_range(2, 0))
          0: pend_q.push_back(base_item('0));
          1: pend_q.push_back(base_item(BASE_HIGH));
          default: pend_q.push_back(base_item(ADDR_W'($urandom_range(BASE_HIGH, 0))));
        endcase
      end
      if ($urandom_range(9, 0) < 6) begin
        pend_q.push_back(req_item(REQ_W'($urandom_range(104, 0))));
      end else begin
        pend_q.push_back(req_item(REQ_W'($urandom())));
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: everything presented, accepted and answered.
    @(negedge clk);
    while (pend_q.size() != 0 || start || cfg_valid || grant_q.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);

    if (!failed) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
